// File: hdl/avmh_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the ordering function for the absolute-value min-heap.
// No dependencies; every module of the block imports this package.
package avmh_pkg;

    localparam int HEAP_DEPTH_DEF = 1024;
    localparam int DATA_W         = 32;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_PUSH_OK   = 2'd0;
    localparam logic [1:0] ST_PUSH_FULL = 2'd1;
    localparam logic [1:0] ST_POPPED    = 2'd2;
    localparam logic [1:0] ST_POP_EMPTY = 2'd3;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [1:0]               status;
    } rsp_word_t;

    // True when p must sit strictly above q in the heap. The most negative
    // value keeps its own bit pattern as magnitude, which is 2^31 unsigned.
    function automatic logic precedes(input logic [DATA_W-1:0] p,
                                      input logic [DATA_W-1:0] q);
        logic [DATA_W-1:0] mp;
        logic [DATA_W-1:0] mq;
        mp = p[DATA_W-1] ? (~p + 1'b1) : p;
        mq = q[DATA_W-1] ? (~q + 1'b1) : q;
        if (mp != mq)
        begin
            return mp < mq;
        end
        return $signed(p) < $signed(q);
    endfunction

endpackage

// File: hdl/absolute_value_min_heap_unit.sv
`timescale 1ns / 1ps
// Absolute-value min-heap priority queue: sequencer, heap memory and result register.
// Depends on avmh_pkg for word types, status codes and the ordering function.
//
// Usage: a command word (push or pop) enters on cmd_valid/cmd_stall; every
// command yields exactly one response word on rsp_valid/rsp_stall. A push
// answers with status push-ok or push-full (dropped); a pop answers with the
// top value and status popped, or 0 and pop-empty.
// One command at a time: cmd_stall stays high from acceptance until the
// response word has been taken, and the next command is accepted once the
// sequencer is back in idle. All work goes through one memory read port and
// one write port, and the memory read is registered. A push climbs level by
// level from the new last slot and stops at the root or below it; a pop moves
// the last value to the root, descends level by level and stops at a leaf or
// above it. A full push and an empty pop answer without touching the memory.
// Reset clears the element count and the sequencer; memory contents are left
// as they are and never read above the count. While rsp_stall is high the
// response word holds and no new command is accepted.
module absolute_value_min_heap_unit
    import avmh_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    localparam int IW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int XW = CW + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_RD    = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_POP_TOP  = 4'd3;
    localparam logic [3:0] S_POP_LAST = 4'd4;
    localparam logic [3:0] S_DN_L     = 4'd5;
    localparam logic [3:0] S_DN_LW    = 4'd6;
    localparam logic [3:0] S_DN_RW    = 4'd7;
    localparam logic [3:0] S_DN_CMP   = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [DATA_W-1:0] heap_mem [HEAP_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    logic [3:0]        state_reg,  state_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic [IW-1:0]     pos_reg,    pos_next;
    logic [IW-1:0]     pick_reg,   pick_next;
    logic [DATA_W-1:0] val_reg,    val_next;
    logic [DATA_W-1:0] lval_reg,   lval_next;
    logic [DATA_W-1:0] pval_reg,   pval_next;
    logic [DATA_W-1:0] top_reg,    top_next;
    rsp_word_t         rsp_reg,    rsp_next;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [IW-1:0]     mem_raddr;

    logic              cmd_take;
    logic [XW-1:0]     left_idx;
    logic [XW-1:0]     right_idx;
    logic [IW-1:0]     parent_idx;
    logic [IW-1:0]     last_idx;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_take   = cmd_valid && !cmd_stall;
    assign rsp_valid  = (state_reg == S_OUT);
    assign rsp        = rsp_reg;

    assign left_idx   = {{(XW-IW-1){1'b0}}, pos_reg, 1'b1};
    assign right_idx  = left_idx + XW'(1);
    assign parent_idx = (pos_reg - IW'(1)) >> 1;
    assign last_idx   = count_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= heap_mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        pick_next  = pick_reg;
        val_next   = val_reg;
        lval_next  = lval_reg;
        pval_next  = pval_reg;
        top_next   = top_reg;
        rsp_next   = rsp_reg;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg;
        mem_wdata  = val_reg;
        mem_raddr  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    if (cmd.command == CMD_PUSH)
                    begin
                        if (count_reg >= CW'(HEAP_DEPTH))
                        begin
                            rsp_next   = '{top_value: '0, status: ST_PUSH_FULL};
                            state_next = S_OUT;
                        end
                        else
                        begin
                            pos_next   = count_reg[IW-1:0];
                            count_next = count_reg + CW'(1);
                            val_next   = cmd.value;
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_next   = '{top_value: '0, status: ST_POP_EMPTY};
                            state_next = S_OUT;
                        end
                        else
                        begin
                            // Read the root now; the last slot is read next cycle.
                            mem_raddr  = '0;
                            count_next = count_reg - CW'(1);
                            state_next = S_POP_TOP;
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    rsp_next   = '{top_value: '0, status: ST_PUSH_OK};
                    state_next = S_OUT;
                end
                else
                begin
                    mem_raddr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (precedes(val_reg, rdata_reg))
                begin
                    // Parent moves down into the hole; the hole climbs.
                    mem_we     = 1'b1;
                    mem_wdata  = rdata_reg;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    mem_we     = 1'b1;
                    rsp_next   = '{top_value: '0, status: ST_PUSH_OK};
                    state_next = S_OUT;
                end
            end
            S_POP_TOP:
            begin
                top_next   = rdata_reg;
                mem_raddr  = last_idx;
                state_next = S_POP_LAST;
            end
            S_POP_LAST:
            begin
                val_next   = rdata_reg;
                pos_next   = '0;
                state_next = S_DN_L;
            end
            S_DN_L:
            begin
                if (left_idx >= XW'(count_reg))
                begin
                    mem_we     = 1'b1;
                    rsp_next   = '{top_value: top_reg, status: ST_POPPED};
                    state_next = S_OUT;
                end
                else
                begin
                    mem_raddr  = left_idx[IW-1:0];
                    state_next = S_DN_LW;
                end
            end
            S_DN_LW:
            begin
                lval_next = rdata_reg;
                if (right_idx < XW'(count_reg))
                begin
                    mem_raddr  = right_idx[IW-1:0];
                    state_next = S_DN_RW;
                end
                else
                begin
                    pick_next  = left_idx[IW-1:0];
                    pval_next  = rdata_reg;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_RW:
            begin
                if (precedes(rdata_reg, lval_reg))
                begin
                    pick_next = right_idx[IW-1:0];
                    pval_next = rdata_reg;
                end
                else
                begin
                    pick_next = left_idx[IW-1:0];
                    pval_next = lval_reg;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (precedes(pval_reg, val_reg))
                begin
                    // Smaller child moves up into the hole; the hole descends.
                    mem_wdata  = pval_reg;
                    pos_next   = pick_reg;
                    state_next = S_DN_L;
                end
                else
                begin
                    rsp_next   = '{top_value: top_reg, status: ST_POPPED};
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        pick_reg <= pick_next;
        val_reg  <= val_next;
        lval_reg <= lval_next;
        pval_reg <= pval_next;
        top_reg  <= top_next;
        rsp_reg  <= rsp_next;
    end

    // The count never exceeds the heap capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HEAP_DEPTH))
        else $error("element count above capacity");

    // A push on a full heap is answered at once with the full status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && cmd.command == CMD_PUSH && count_reg == CW'(HEAP_DEPTH))
        |=> (rsp_valid && rsp.status == ST_PUSH_FULL && count_reg == CW'(HEAP_DEPTH)))
        else $error("full push not dropped");

    // A pop on an empty heap is answered at once with the empty status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && cmd.command == CMD_POP && count_reg == '0)
        |=> (rsp_valid && rsp.status == ST_POP_EMPTY && rsp.top_value == '0))
        else $error("empty pop misreported");

    // An accepted push with room grows the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && cmd.command == CMD_PUSH && count_reg < CW'(HEAP_DEPTH))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow count");

    // No new command is taken while a response word is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cmd_stall)
        else $error("command accepted while response pending");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for absolute_value_min_heap_unit: directed, random and full-heap tests
// checked against a heap predictor in this file. Depends on avmh_pkg and the unit.
module tb;
    import avmh_pkg::*;

    localparam int DEPTH = HEAP_DEPTH_DEF;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    absolute_value_min_heap_unit #(
        .HEAP_DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Predicted heap contents and size, updated when a command word is accepted.
    logic [31:0] heap_model [0:DEPTH-1];
    int unsigned heap_size = 0;
    rsp_word_t   replies_due [$];

    int mismatch_count = 0;
    int n_push_ok      = 0;
    int n_push_full    = 0;
    int n_popped       = 0;
    int n_pop_empty    = 0;
    int peak_size      = 0;

    int burst_left   = 0;
    int episode_left = 0;
    int stall_mode   = 0;
    int mode_left    = 0;
    int run_left     = 0;
    bit stall_run    = 1'b0;

    // Order by magnitude, ties broken toward the more negative value.
    // The most negative value negates to itself, which reads as 2^31 unsigned.
    function automatic bit ranks_above(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        mag_a = a[31] ? (32'd0 - a) : a;
        mag_b = b[31] ? (32'd0 - b) : b;
        if (mag_a != mag_b)
        begin
            return mag_a < mag_b;
        end
        return $signed(a) < $signed(b);
    endfunction

    function automatic rsp_word_t heap_apply(input cmd_word_t w);
        rsp_word_t   r;
        int unsigned slot;
        int unsigned up;
        int unsigned kid;
        logic [31:0] tmp;
        r.top_value = '0;
        if (w.command == CMD_PUSH)
        begin
            if (heap_size >= DEPTH)
            begin
                r.status = ST_PUSH_FULL;
            end
            else
            begin
                slot = heap_size;
                heap_model[slot] = w.value;
                heap_size++;
                while (slot > 0)
                begin
                    up = (slot - 1) / 2;
                    if (!ranks_above(heap_model[slot], heap_model[up]))
                    begin
                        break;
                    end
                    tmp = heap_model[slot];
                    heap_model[slot] = heap_model[up];
                    heap_model[up] = tmp;
                    slot = up;
                end
                r.status = ST_PUSH_OK;
            end
        end
        else if (heap_size == 0)
        begin
            r.status = ST_POP_EMPTY;
        end
        else
        begin
            r.top_value = heap_model[0];
            heap_size--;
            heap_model[0] = heap_model[heap_size];
            slot = 0;
            forever
            begin
                kid = 2 * slot + 1;
                if (kid >= heap_size)
                begin
                    break;
                end
                if (kid + 1 < heap_size && ranks_above(heap_model[kid + 1], heap_model[kid]))
                begin
                    kid++;
                end
                if (!ranks_above(heap_model[kid], heap_model[slot]))
                begin
                    break;
                end
                tmp = heap_model[slot];
                heap_model[slot] = heap_model[kid];
                heap_model[kid] = tmp;
                slot = kid;
            end
            r.status = ST_POPPED;
        end
        return r;
    endfunction

    // Small magnitudes are common so that ties in magnitude and equal values occur.
    function automatic logic [31:0] pick_value();
        logic [31:0] m;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: m = $urandom_range(0, 8);
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            5: m = 32'd1 << $urandom_range(0, 30);
            default: return $urandom();
        endcase
        return $urandom_range(0, 1) ? (32'd0 - m) : m;
    endfunction

    task automatic send_word(input logic op, input logic [31:0] v);
        cmd_word_t w;
        rsp_word_t want;
        int        gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        w.command = op;
        w.value   = v;
        cmd       <= w;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        want = heap_apply(w);
        replies_due.push_back(want);
        case (want.status)
            ST_PUSH_OK:   n_push_ok++;
            ST_PUSH_FULL: n_push_full++;
            ST_POPPED:    n_popped++;
            default:      n_pop_empty++;
        endcase
        if (heap_size > peak_size)
        begin
            peak_size = heap_size;
        end
    endtask

    // Holds the sender until every owed response word has been taken.
    task automatic pause_sender();
        cmd_valid <= 1'b0;
        while (replies_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        send_word(CMD_POP, 32'd0);
        send_word(CMD_PUSH, 32'd5);
        send_word(CMD_PUSH, 32'hFFFF_FFFB);
        send_word(CMD_PUSH, 32'd5);
        send_word(CMD_PUSH, 32'd0);
        send_word(CMD_PUSH, 32'h7FFF_FFFF);
        send_word(CMD_PUSH, 32'h8000_0001);
        send_word(CMD_PUSH, 32'h8000_0000);
        send_word(CMD_PUSH, 32'hFFFF_FFFF);
        send_word(CMD_PUSH, 32'd1);
        send_word(CMD_PUSH, 32'hFFFF_FFFB);
        repeat (11) send_word(CMD_POP, $urandom());
    endtask

    // Heap stays small here; each episode has its own size cap and pop bias.
    task automatic test_random_mix(input int count);
        int cap;
        int bias;
        cap  = 8;
        bias = 50;
        repeat (count)
        begin
            if (episode_left == 0)
            begin
                cap = $urandom_range(1, 64);
                bias = $urandom_range(20, 80);
                episode_left = $urandom_range(10, 80);
            end
            episode_left--;
            if ($urandom_range(1, 100) <= ((heap_size > cap) ? 85 : bias))
            begin
                send_word(CMD_POP, $urandom());
            end
            else
            begin
                send_word(CMD_PUSH, pick_value());
            end
        end
    endtask

    task automatic test_full_heap(input int tail);
        while (heap_size < DEPTH)
        begin
            send_word(CMD_PUSH, pick_value());
        end
        send_word(CMD_PUSH, pick_value());
        send_word(CMD_PUSH, 32'h8000_0000);
        send_word(CMD_POP, 32'd0);
        send_word(CMD_PUSH, pick_value());
        send_word(CMD_PUSH, 32'd0);
        repeat (tail)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_word(CMD_PUSH, pick_value());
            end
            else
            begin
                send_word(CMD_POP, $urandom());
            end
        end
    endtask

    always @(posedge clk)
    begin : check_rsp
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (replies_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected word: top_value %0d status %0d", $time,
                         rsp.top_value, rsp.status);
            end
            else
            begin
                want = replies_due.pop_front();
                if (rsp.status !== want.status)
                begin
                    mismatch_count++;
                    $display("%0t: status expected %0d, actual %0d", $time,
                             want.status, rsp.status);
                end
                if (rsp.top_value !== want.top_value)
                begin
                    mismatch_count++;
                    $display("%0t: top_value expected %0d, actual %0d", $time,
                             want.top_value, rsp.top_value);
                end
            end
        end
    end

    // The receiver switches between no stalls, scattered stalls and long stall runs.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(30, 300);
        end
        mode_left--;
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (run_left == 0)
                begin
                    run_left = stall_run ? $urandom_range(1, 5) : $urandom_range(1, 20);
                    stall_run = ~stall_run;
                end
                run_left--;
                rsp_stall <= stall_run;
            end
        endcase
    end

    initial
    begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        pause_sender();
        test_random_mix(700);
        pause_sender();
        test_full_heap(100);
        pause_sender();
        repeat (60) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d response words never arrived", $time, replies_due.size());
        end
        $display("Covered %0d accepted pushes, %0d pushes dropped on a full heap,",
                 n_push_ok, n_push_full);
        $display("%0d pops, %0d pops on an empty heap; largest heap held %0d values.",
                 n_popped, n_pop_empty, peak_size);
        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
